// ===== hdl/multi_level_priority_fifo_macros.svh =====
// Assertion macros shared by the priority queue RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef MULTI_LEVEL_PRIORITY_FIFO_MACROS_SVH
`define MULTI_LEVEL_PRIORITY_FIFO_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked in the same cycle, suspended during reset.
`define MLPF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent, active during reset as well.
`define MLPF_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MLPF_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MLPF_ASSERT_NEXT(label, clk, ante, cons, msg)

`endif

`endif

// ===== hdl/mlpf_pkg.sv =====
// Shared codes and types for the multi-level priority queue.
// Depends on nothing; used by the top level by scoped names.
package mlpf_pkg;

   localparam int PRI_W    = 6;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;

   typedef logic [STATUS_W-1:0] status_type;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   localparam status_type ST_PUSHED = 3'd0;
   localparam status_type ST_POPPED = 3'd1;
   localparam status_type ST_EMPTY  = 3'd2;
   localparam status_type ST_FULL   = 3'd3;
   localparam status_type ST_BADPRI = 3'd4;

endpackage

// ===== hdl/multi_level_priority_fifo.sv =====
// Multi-level priority queue: LEVELS circular FIFOs, lowest level number served first.
// A push passes S_META, a rejected request S_EMIT and a pop S_META then S_READ before rsp_tvalid
// rises. A new request is taken only back in S_IDLE, paced by the read-modify-write of the level
// metadata RAM and the registered read of the slot RAM, and held while rsp_tready stalls output.
// Reset (synchronous): clears per-level valid bits and the non-empty map, so pointers
// and counts read as zero at once; the slot RAM is not cleared and needs no sweep.
`include "multi_level_priority_fifo_macros.svh"

module multi_level_priority_fifo #(
   parameter int LEVELS      = 32,
   parameter int LEVEL_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [5:0] priority_req, [37:6] item_value, [39:38] zero
   input  logic [0:0]  req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PW  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CW  = $clog2(LEVEL_DEPTH + 1);
   localparam int MW  = CW + 2 * PW;
   localparam int SD  = LEVELS * LEVEL_DEPTH;
   localparam int SAW = $clog2(SD);
   localparam int VW  = mlpf_pkg::VALUE_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_META = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic        kind_ff, kind_in;
   logic [VW-1:0] item_ff, item_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   mlpf_pkg::status_type status_ff, status_in;

   logic [LEVELS-1:0] nonempty_ff, nonempty_in;
   logic [LEVELS-1:0] meta_valid_ff, meta_valid_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_value_ff, rsp_value_in;
   mlpf_pkg::status_type rsp_status_ff, rsp_status_in;

   // Metadata RAM: {count, tail, head} per level.
   logic          meta_rd_en, meta_wr_en;
   logic [LW-1:0] meta_rd_addr;
   logic [MW-1:0] meta_wr_data, meta_rd_data, meta_cur;
   logic [PW-1:0] cur_head, cur_tail, next_ptr, sel_ptr;
   logic [CW-1:0] cur_count;

   logic           slot_rd_en, slot_wr_en;
   logic [SAW-1:0] slot_addr;
   logic [VW-1:0]  slot_rd_data;

   logic                        accept, out_free, pri_bad;
   logic [mlpf_pkg::PRI_W-1:0]  req_pri;
   logic [LW-1:0]               first_lvl, push_lvl;

   assign req_pri    = req_tdata[mlpf_pkg::PRI_W-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign pri_bad    = (req_pri == '0) || ({1'b0, req_pri} > 7'(LEVELS));
   assign push_lvl   = LW'(req_pri - 6'd1);

   always_comb begin
      first_lvl = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            first_lvl = LW'(i);
         end
      end
   end

   // A level never written reads as all-zero metadata.
   assign meta_cur  = meta_valid_ff[lvl_ff] ? meta_rd_data : '0;
   assign cur_head  = meta_cur[PW-1:0];
   assign cur_tail  = meta_cur[2*PW-1:PW];
   assign cur_count = meta_cur[MW-1:2*PW];
   assign sel_ptr   = (kind_ff == mlpf_pkg::KIND_PUSH) ? cur_tail : cur_head;
   assign next_ptr  = (sel_ptr == PW'(LEVEL_DEPTH - 1)) ? '0 : PW'(sel_ptr + 1'b1);
   assign slot_addr = SAW'(SAW'(lvl_ff) * SAW'(LEVEL_DEPTH)) + SAW'(sel_ptr);

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      item_in       = item_ff;
      lvl_in        = lvl_ff;
      status_in     = status_ff;
      nonempty_in   = nonempty_ff;
      meta_valid_in = meta_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      meta_rd_en    = 1'b0;
      meta_rd_addr  = push_lvl;
      meta_wr_en    = 1'b0;
      meta_wr_data  = meta_cur;
      slot_rd_en    = 1'b0;
      slot_wr_en    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in = req_tuser[0];
               item_in = req_tdata[VW+mlpf_pkg::PRI_W-1:mlpf_pkg::PRI_W];
               if (req_tuser[0] == mlpf_pkg::KIND_PUSH) begin
                  lvl_in       = push_lvl;
                  meta_rd_addr = push_lvl;
                  if (pri_bad) begin
                     status_in = mlpf_pkg::ST_BADPRI;
                     state_in  = S_EMIT;
                  end else begin
                     meta_rd_en = 1'b1;
                     state_in   = S_META;
                  end
               end else begin
                  lvl_in       = first_lvl;
                  meta_rd_addr = first_lvl;
                  if (nonempty_ff == '0) begin
                     status_in = mlpf_pkg::ST_EMPTY;
                     state_in  = S_EMIT;
                  end else begin
                     meta_rd_en = 1'b1;
                     state_in   = S_META;
                  end
               end
            end
         end
         S_META: begin
            if (kind_ff == mlpf_pkg::KIND_PUSH) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
                  state_in     = S_IDLE;
                  if (cur_count == CW'(LEVEL_DEPTH)) begin
                     rsp_status_in = mlpf_pkg::ST_FULL;
                  end else begin
                     rsp_status_in         = mlpf_pkg::ST_PUSHED;
                     slot_wr_en            = 1'b1;
                     meta_wr_en            = 1'b1;
                     meta_wr_data          = {CW'(cur_count + 1'b1), next_ptr, cur_head};
                     meta_valid_in[lvl_ff] = 1'b1;
                     nonempty_in[lvl_ff]   = 1'b1;
                  end
               end
            end else begin
               slot_rd_en            = 1'b1;
               meta_wr_en            = 1'b1;
               meta_wr_data          = {CW'(cur_count - 1'b1), cur_tail, next_ptr};
               meta_valid_in[lvl_ff] = 1'b1;
               if (cur_count == CW'(1)) begin
                  nonempty_in[lvl_ff] = 1'b0;
               end
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = slot_rd_data;
               rsp_status_in = mlpf_pkg::ST_POPPED;
               state_in      = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         nonempty_ff   <= '0;
         meta_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nonempty_ff   <= nonempty_in;
         meta_valid_ff <= meta_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      item_ff       <= item_in;
      lvl_ff        <= lvl_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   mlpf_ram #(
      .WIDTH (MW),
      .DEPTH (LEVELS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (lvl_ff),
      .wr_data (meta_wr_data),
      .rd_en   (meta_rd_en),
      .rd_addr (meta_rd_addr),
      .rd_data (meta_rd_data)
   );

   mlpf_ram #(
      .WIDTH (VW),
      .DEPTH (SD)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_addr),
      .wr_data (item_ff),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_addr),
      .rd_data (slot_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   // A granted pop must find a level whose stored count agrees with the non-empty map.
   `MLPF_ASSERT_IMP(a_pop_level_nonempty, clock, reset, (state_ff == S_META) && (kind_ff == mlpf_pkg::KIND_POP), (cur_count != '0), "pop granted to an empty level")
   // A level count can never exceed the level depth.
   `MLPF_ASSERT_IMP(a_count_bound, clock, reset, (state_ff == S_META), (cur_count <= CW'(LEVEL_DEPTH)), "level count above depth")
   // The slot read state is only reached from the metadata stage of a pop.
   `MLPF_ASSERT_IMP(a_read_after_meta, clock, reset, (state_ff == S_READ) && ($past(state_ff) != S_READ), ($past(state_ff) == S_META) && ($past(kind_ff) == mlpf_pkg::KIND_POP), "slot read without metadata stage")
   // Reset leaves every level empty and nothing pending on the response side.
   `MLPF_ASSERT_NEXT(a_reset_clears, clock, reset, (nonempty_ff == '0) && (meta_valid_ff == '0) && !rsp_valid_ff, "state not cleared by reset")

endmodule

// ===== hdl/mlpf_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing; instanced by the priority queue top level.
module mlpf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== dv/multi_level_priority_fifo_tb.sv =====
// Self-checking testbench for the multi-level priority queue (push/pop stream).
// Depends on mlpf_pkg and multi_level_priority_fifo; runs a directed table, then
// random push/pop traffic checked against an in-bench model of the level FIFOs.
`timescale 1ns / 100ps

module multi_level_priority_fifo_tb;

   localparam int LEVELS = 32;
   localparam int DEPTH  = 64;
   localparam int TARGET_REQUESTS = 900;

   typedef struct packed {
      logic [31:0]          value;
      mlpf_pkg::status_type status;
   } outcome_type;

   typedef struct packed {
      logic                 kind;
      logic [5:0]           pri;
      logic [31:0]          word;
      logic                 typed;
      logic [31:0]          exp_value;
      mlpf_pkg::status_type exp_status;
   } request_row_type;

   // Rows with typed = 1 carry their own expected result; the rest use the model.
   localparam request_row_type OPENING_ROWS [24] = '{
      '{mlpf_pkg::KIND_POP,  6'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, mlpf_pkg::ST_EMPTY},
      '{mlpf_pkg::KIND_POP,  6'd63, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, mlpf_pkg::ST_EMPTY},
      '{mlpf_pkg::KIND_PUSH, 6'd0,  32'h1234_5678, 1'b1, 32'h0000_0000, mlpf_pkg::ST_BADPRI},
      '{mlpf_pkg::KIND_PUSH, 6'd33, 32'h8765_4321, 1'b1, 32'h0000_0000, mlpf_pkg::ST_BADPRI},
      '{mlpf_pkg::KIND_PUSH, 6'd63, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, mlpf_pkg::ST_BADPRI},
      '{mlpf_pkg::KIND_POP,  6'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, mlpf_pkg::ST_EMPTY},
      '{mlpf_pkg::KIND_PUSH, 6'd32, 32'h8000_0000, 1'b1, 32'h0000_0000, mlpf_pkg::ST_PUSHED},
      '{mlpf_pkg::KIND_PUSH, 6'd1,  32'h7FFF_FFFF, 1'b1, 32'h0000_0000, mlpf_pkg::ST_PUSHED},
      '{mlpf_pkg::KIND_PUSH, 6'd1,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, mlpf_pkg::ST_PUSHED},
      '{mlpf_pkg::KIND_PUSH, 6'd16, 32'h0000_0000, 1'b1, 32'h0000_0000, mlpf_pkg::ST_PUSHED},
      '{mlpf_pkg::KIND_PUSH, 6'd2,  32'hA5A5_A5A5, 1'b1, 32'h0000_0000, mlpf_pkg::ST_PUSHED},
      '{mlpf_pkg::KIND_POP,  6'd21, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, mlpf_pkg::ST_POPPED},
      '{mlpf_pkg::KIND_PUSH, 6'd1,  32'h0000_0001, 1'b1, 32'h0000_0000, mlpf_pkg::ST_PUSHED},
      '{mlpf_pkg::KIND_POP,  6'd63, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, mlpf_pkg::ST_POPPED},
      '{mlpf_pkg::KIND_POP,  6'd0,  32'h0000_0000, 1'b1, 32'h0000_0001, mlpf_pkg::ST_POPPED},
      '{mlpf_pkg::KIND_POP,  6'd5,  32'hDEAD_BEEF, 1'b1, 32'hA5A5_A5A5, mlpf_pkg::ST_POPPED},
      '{mlpf_pkg::KIND_POP,  6'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, mlpf_pkg::ST_POPPED},
      '{mlpf_pkg::KIND_POP,  6'd0,  32'h0000_0000, 1'b1, 32'h8000_0000, mlpf_pkg::ST_POPPED},
      '{mlpf_pkg::KIND_POP,  6'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, mlpf_pkg::ST_EMPTY},
      '{mlpf_pkg::KIND_PUSH, 6'd32, 32'h5A5A_5A5A, 1'b0, 32'h0000_0000, mlpf_pkg::ST_PUSHED},
      '{mlpf_pkg::KIND_PUSH, 6'd31, 32'hC3C3_C3C3, 1'b0, 32'h0000_0000, mlpf_pkg::ST_PUSHED},
      '{mlpf_pkg::KIND_POP,  6'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, mlpf_pkg::ST_PUSHED},
      '{mlpf_pkg::KIND_POP,  6'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, mlpf_pkg::ST_PUSHED},
      '{mlpf_pkg::KIND_POP,  6'd0,  32'h0000_0000, 1'b0, 32'h0000_0000, mlpf_pkg::ST_PUSHED}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [5:0] priority_req, [37:6] item_value, [39:38] zero
   logic [0:0]  req_tuser = '0;   // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] value
   logic [2:0]  rsp_tuser;        // [2:0] status

   // Model of the queue state.
   logic [31:0] slot_mem [LEVELS][DEPTH];
   logic [5:0]  head_ptr [LEVELS];
   logic [5:0]  tail_ptr [LEVELS];
   logic [6:0]  level_used [LEVELS];
   logic [11:0] total_held;

   outcome_type     awaited_outcomes [$];
   request_row_type current_row = '0;
   int              sent_count = 0;
   bit              steady_run = 1'b0;
   int              error_count = 0;
   int              status_tally [8];

   multi_level_priority_fifo #(
      .LEVELS      (LEVELS),
      .LEVEL_DEPTH (DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Applies one request to the model and returns the result it should give.
   function automatic outcome_type apply_request(input logic kind, input logic [5:0] pri,
                                                 input logic [31:0] word);
      outcome_type res;
      int          lv;
      bit          found;
      res.value  = '0;
      res.status = mlpf_pkg::ST_EMPTY;
      found      = 1'b0;
      if (kind == mlpf_pkg::KIND_PUSH) begin
         if (pri == 6'd0 || pri > LEVELS) begin
            res.status = mlpf_pkg::ST_BADPRI;
         end else if (level_used[pri-1] >= DEPTH) begin
            res.status = mlpf_pkg::ST_FULL;
         end else begin
            lv = pri - 1;
            slot_mem[lv][tail_ptr[lv]] = word;
            tail_ptr[lv]   = (tail_ptr[lv] == DEPTH-1) ? 6'd0 : tail_ptr[lv] + 6'd1;
            level_used[lv] = level_used[lv] + 7'd1;
            total_held     = total_held + 12'd1;
            res.status     = mlpf_pkg::ST_PUSHED;
         end
      end else if (total_held != 0) begin
         for (lv = 0; lv < LEVELS; lv++) begin
            if (!found && level_used[lv] != 0) begin
               res.value      = slot_mem[lv][head_ptr[lv]];
               head_ptr[lv]   = (head_ptr[lv] == DEPTH-1) ? 6'd0 : head_ptr[lv] + 6'd1;
               level_used[lv] = level_used[lv] - 7'd1;
               total_held     = total_held - 12'd1;
               res.status     = mlpf_pkg::ST_POPPED;
               found          = 1'b1;
            end
         end
      end
      return res;
   endfunction

   // Requests are predicted from the bus itself; responses are checked in order.
   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ptr[i]   = '0;
            tail_ptr[i]   = '0;
            level_used[i] = '0;
         end
         total_held = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            got = apply_request(req_tuser[0], req_tdata[5:0], req_tdata[37:6]);
            if (current_row.typed)
               awaited_outcomes.push_back(outcome_type'{current_row.exp_value,
                                                        current_row.exp_status});
            else
               awaited_outcomes.push_back(got);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_outcomes.size() == 0) begin
               report_mismatch("response with no request outstanding", rsp_tdata, '0);
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_tdata !== want.value)
                  report_mismatch("value", rsp_tdata, want.value);
               if (rsp_tuser !== want.status)
                  report_mismatch("status", {29'd0, rsp_tuser}, {29'd0, want.status});
               status_tally[want.status]++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= steady_run || ($urandom_range(0, 99) >= 21);
   end

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 11))
         0:       return 32'h0000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic request_row_type make_row(input logic kind, input logic [5:0] pri,
                                                input logic [31:0] word);
      request_row_type row;
      row       = '0;
      row.kind  = kind;
      row.pri   = pri;
      row.word  = word;
      return row;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance with
   // tvalid still high, so back-to-back requests never toggle it within a step.
   task automatic send_request(input request_row_type row);
      while (!steady_run && $urandom_range(0, 99) < 21) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid  <= 1'b1;
      req_tuser   <= row.kind;
      req_tdata   <= {2'b00, row.word, row.pri};
      current_row <= row;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      steady_run = (sent_count >= 400 && sent_count < 540);
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_pop();
      send_request(make_row(mlpf_pkg::KIND_POP, 6'($urandom_range(0, 63)), $urandom()));
   endtask

   // Overfills one level so the full case and pointer wrap are reached.
   task automatic run_fill_episode();
      int target;
      int burst;
      target = $urandom_range(1, LEVELS);
      burst  = DEPTH - level_used[target-1] + $urandom_range(1, 6);
      repeat (burst) begin
         if ($urandom_range(0, 7) == 0)
            send_request(make_row(mlpf_pkg::KIND_PUSH, 6'($urandom_range(1, LEVELS)),
                                  random_word()));
         else
            send_request(make_row(mlpf_pkg::KIND_PUSH, 6'(target), random_word()));
      end
      repeat ($urandom_range(30, 90)) send_random_pop();
   endtask

   task automatic run_mixed_episode();
      int push_pct;
      logic [5:0] pri;
      push_pct = $urandom_range(30, 70);
      repeat ($urandom_range(40, 80)) begin
         if ($urandom_range(0, 99) < push_pct) begin
            if ($urandom_range(0, 99) < 12)
               pri = 6'($urandom_range(0, 63));
            else
               pri = 6'($urandom_range(1, LEVELS));
            send_request(make_row(mlpf_pkg::KIND_PUSH, pri, random_word()));
         end else begin
            send_random_pop();
         end
      end
   endtask

   task automatic run_drain_episode();
      while (total_held != 0) send_random_pop();
      repeat (2) send_random_pop();
   endtask

   initial begin
      int pick;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (OPENING_ROWS[i]) send_request(OPENING_ROWS[i]);
      wait_until_drained();

      run_fill_episode();
      while (sent_count < TARGET_REQUESTS) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            run_mixed_episode();
         end else if (pick < 8) begin
            run_fill_episode();
         end else begin
            wait_until_drained();
            run_drain_episode();
         end
      end
      run_drain_episode();
      req_tvalid <= 1'b0;

      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Run covered %0d requests: %0d stored, %0d served, %0d empty pops,",
               sent_count, status_tally[mlpf_pkg::ST_PUSHED],
               status_tally[mlpf_pkg::ST_POPPED], status_tally[mlpf_pkg::ST_EMPTY]);
      $display("%0d pushes refused on a full level and %0d on a bad priority.",
               status_tally[mlpf_pkg::ST_FULL], status_tally[mlpf_pkg::ST_BADPRI]);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
